// File: hw/rtl/pbhd_pkg.sv
// ----------------------------------------------------------------------------
// pbhd_pkg
// Shared types and constants for the pre-order Huffman bit decoder.
// ----------------------------------------------------------------------------
package pbhd_pkg;

   // node numbering: leaves 0..255, internal nodes 256..510
   localparam int NODE_W    = 9;
   localparam int SYM_W     = 8;
   localparam int COUNT_W   = 24;
   localparam int LINK_AW   = 9;
   localparam int LEAF_CW   = 3;

   localparam logic [NODE_W-1:0]  NODE_FIRST    = 9'd256;
   localparam logic [NODE_W-1:0]  NODE_LIMIT    = 9'd511;
   localparam logic [SYM_W-1:0]   OVERFLOW_LEAF = 8'hFF;
   localparam logic [LEAF_CW-1:0] LEAF_LAST_BIT = 3'd7;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_BITS  = 1'd1;

   // result queue
   localparam int RSPQ_DEPTH = 3;
   localparam int RSPQ_CW    = 2;

   typedef struct packed {
      logic code_bit;
      logic stream_start;
   } req_word_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } rsp_word_type;

   // open tree node on the pending stack
   typedef struct packed {
      logic             side;
      logic [SYM_W-1:0] offset;
   } stack_entry_type;

   typedef enum logic [1:0] {
      PH_MARK = 2'd0,
      PH_LEAF = 2'd1,
      PH_WALK = 2'd2
   } phase_type;

endpackage

// File: hw/rtl/pbhd_ram.sv
// ----------------------------------------------------------------------------
// pbhd_ram
// Generic simple dual-port RAM, registered read, write-first on collision.
// ----------------------------------------------------------------------------
module pbhd_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pbhd_rsp_queue.sv
// ----------------------------------------------------------------------------
// pbhd_rsp_queue
// Three-word result queue; head entry is the output register.
// ----------------------------------------------------------------------------
module pbhd_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  pbhd_pkg::rsp_word_type push_word,
   input  logic                   pop_ready,
   output logic                   rsp_valid,
   output pbhd_pkg::rsp_word_type rsp_word,
   output logic [pbhd_pkg::RSPQ_CW-1:0] fill
);
   import pbhd_pkg::*;

   rsp_word_type       entry_ff [RSPQ_DEPTH];
   rsp_word_type       entry_in [RSPQ_DEPTH];
   logic [RSPQ_CW-1:0] count_ff;
   logic [RSPQ_CW-1:0] count_in;
   logic [RSPQ_CW-1:0] wr_idx;
   logic               pop;

   always_comb begin
      pop      = pop_ready && (count_ff != '0);
      entry_in = entry_ff;
      if (pop) begin
         for (int i = 0; i < RSPQ_DEPTH - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
      end
      wr_idx = count_ff - RSPQ_CW'(pop);
      if (push_valid && (wr_idx < RSPQ_CW'(RSPQ_DEPTH))) begin
         entry_in[wr_idx] = push_word;
      end
      count_in = count_ff - RSPQ_CW'(pop) + RSPQ_CW'(push_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entry_ff[0];
   assign fill      = count_ff;

endmodule

// File: hw/rtl/preorder_huffman_bit_decoder_core.sv
// ----------------------------------------------------------------------------
// preorder_huffman_bit_decoder_core
// Bit-serial Huffman decoder with a pre-order tree header.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one compressed bit per word (code_bit, stream_start). A word with
//            stream_start set clears the decoder state and begins a new tree.
//   rsp_*  : one decoded byte per word (symbol, last). Header bits and
//            internal tree steps produce no word.
//   csr_*  : symbol_count and invert_bits; write only while idle.
// Throughput: one bit per cycle unless stalled. The tree-link RAM read for a
//   bit is issued when the bit is accepted, addressed by the walk node that
//   the previous bit leaves; its registered data is consumed the next cycle.
// Result path: an accepted bit sits in the input register (e_*); a symbol it
//   completes goes into the result queue and reaches rsp_* from its head.
// Stall: a 3-word result queue sits at the output; req_ready drops only
//   when the queue plus the bit in flight could overfill it.
// Reset: clears control state, symbol_count = 0, invert_bits = 1. The tree
//   and stack RAMs are not cleared: only written entries are ever used.
// ----------------------------------------------------------------------------
module preorder_huffman_bit_decoder_core #(
   parameter int STACK_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pbhd_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pbhd_pkg::rsp_word_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [pbhd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pbhd_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import pbhd_pkg::*;

   localparam int DW  = $clog2(STACK_DEPTH + 1);   // stack depth counter
   localparam int SAW = $clog2(STACK_DEPTH);       // stack RAM address
   localparam logic [DW-1:0] STACK_FULL = DW'(STACK_DEPTH);

   // configuration
   logic [COUNT_W-1:0] symbol_count_ff;
   logic               invert_ff;

   // execute stage (input register)
   logic e_valid_ff, e_bit_ff, e_start_ff;
   logic req_accept;
   logic req_bit;

   // decoder state
   phase_type         phase_ff, phase_cur, phase_in;
   logic [DW-1:0]     depth_ff, depth_cur, depth_in;
   logic [NODE_W-1:0] next_ff, next_cur, next_in;
   logic [NODE_W-1:0] root_ff, root_cur, root_in;
   logic [NODE_W-1:0] walk_ff, walk_cur, walk_in;
   logic [SYM_W-1:0]  shift_ff, shift_cur, shift_in;
   logic [LEAF_CW-1:0] cnt_ff, cnt_cur, cnt_in;
   logic [COUNT_W-1:0] emitted_ff, emitted_cur, emitted_in;
   stack_entry_type   top_ff, top_in;

   // step scratch
   logic              leaf_done;
   logic [SYM_W-1:0]  leaf_val;
   logic [NODE_W-1:0] link_val;
   logic [DW-1:0]     depth_dec;
   logic [DW-1:0]     depth_rd;

   // RAM ports
   logic                 tw_en;
   logic [LINK_AW-1:0]   tw_addr;
   logic [NODE_W-1:0]    tw_data;
   logic [LINK_AW-1:0]   tr_addr;
   logic [NODE_W-1:0]    tr_data;
   logic                 sw_en;
   logic [SAW-1:0]       sw_addr;
   stack_entry_type      sw_data;
   logic [SAW-1:0]       sr_addr;
   stack_entry_type      sr_data;

   // result path
   logic                 emit;
   rsp_word_type         emit_word;
   logic [RSPQ_CW-1:0]   q_fill;
   logic [RSPQ_CW:0]     q_load;

   // ------------------------------------------------------------------------
   // Handshake and input register
   // ------------------------------------------------------------------------
   // queue words plus the bit in flight must leave room for one more result
   assign q_load     = {1'b0, q_fill} + (RSPQ_CW+1)'(e_valid_ff);
   assign req_ready  = (q_load < (RSPQ_CW+1)'(RSPQ_DEPTH));
   assign req_accept = req_valid && req_ready;
   assign req_bit    = req_data.code_bit ^ invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         e_bit_ff   <= req_bit;
         e_start_ff <= req_data.stream_start;
      end
   end

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
         invert_ff       <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SYMBOL_COUNT: symbol_count_ff <= csr_wr_data;
            CSR_INVERT_BITS:  invert_ff       <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // One decode step per bit
   // ------------------------------------------------------------------------
   always_comb begin
      phase_cur   = phase_ff;
      depth_cur   = depth_ff;
      next_cur    = next_ff;
      root_cur    = root_ff;
      walk_cur    = walk_ff;
      shift_cur   = shift_ff;
      cnt_cur     = cnt_ff;
      emitted_cur = emitted_ff;
      if (e_valid_ff && e_start_ff) begin
         phase_cur   = PH_MARK;
         depth_cur   = '0;
         next_cur    = NODE_FIRST;
         root_cur    = '0;
         walk_cur    = '0;
         shift_cur   = '0;
         cnt_cur     = '0;
         emitted_cur = '0;
      end

      phase_in   = phase_cur;
      depth_in   = depth_cur;
      next_in    = next_cur;
      root_in    = root_cur;
      walk_in    = walk_cur;
      shift_in   = shift_cur;
      cnt_in     = cnt_cur;
      emitted_in = emitted_cur;
      top_in     = top_ff;

      leaf_done = 1'b0;
      leaf_val  = '0;
      link_val  = '0;
      depth_dec = depth_cur - DW'(1);
      tw_en     = 1'b0;
      tw_addr   = {top_ff.offset, top_ff.side};
      tw_data   = '0;
      sw_en     = 1'b0;
      sw_addr   = depth_dec[SAW-1:0];
      sw_data   = '{side: 1'b1, offset: top_ff.offset};
      emit      = 1'b0;
      emit_word = '0;

      if (e_valid_ff) begin
         case (phase_cur)
            PH_MARK: begin
               if (!e_bit_ff) begin
                  shift_in = '0;
                  cnt_in   = '0;
                  phase_in = PH_LEAF;
               end else if ((next_cur != NODE_LIMIT) && (depth_cur < STACK_FULL)) begin
                  // new internal node
                  next_in = next_cur + NODE_W'(1);
                  top_in  = '{side: 1'b0, offset: next_cur[SYM_W-1:0]};
                  if (depth_cur == '0) begin
                     root_in  = next_cur;
                     depth_in = DW'(1);
                  end else begin
                     tw_en   = 1'b1;
                     tw_data = next_cur;
                     if (!top_ff.side) begin
                        // parent stays open on its right side, goes below top
                        sw_en    = 1'b1;
                        depth_in = depth_cur + DW'(1);
                     end
                     // right side filled: parent pops, new node takes its slot
                  end
               end else begin
                  // node numbers or stack used up
                  leaf_done = 1'b1;
                  leaf_val  = OVERFLOW_LEAF;
               end
            end
            PH_LEAF: begin
               shift_in = {shift_cur[SYM_W-2:0], e_bit_ff};
               if (cnt_cur == LEAF_LAST_BIT) begin
                  cnt_in    = '0;
                  leaf_done = 1'b1;
                  leaf_val  = shift_in;
               end else begin
                  cnt_in = cnt_cur + LEAF_CW'(1);
               end
            end
            default: begin
               // walk (unused code behaves the same)
               if (emitted_cur < symbol_count_ff) begin
                  if (!root_cur[NODE_W-1]) begin
                     emit = 1'b1;
                     emit_word.symbol = root_cur[SYM_W-1:0];
                  end else if (tr_data[NODE_W-1]) begin
                     walk_in = tr_data;
                  end else begin
                     emit = 1'b1;
                     emit_word.symbol = tr_data[SYM_W-1:0];
                     walk_in = root_cur;
                  end
                  if (emit) begin
                     emit_word.last = ((emitted_cur + COUNT_W'(1)) == symbol_count_ff);
                     emitted_in     = emitted_cur + COUNT_W'(1);
                  end
               end
            end
         endcase

         if (leaf_done) begin
            link_val = {1'b0, leaf_val};
            if (depth_cur == '0) begin
               root_in  = link_val;
               walk_in  = link_val;
               phase_in = PH_WALK;
            end else begin
               tw_en   = 1'b1;
               tw_data = link_val;
               if (!top_ff.side) begin
                  top_in.side = 1'b1;
                  phase_in    = PH_MARK;
               end else begin
                  // pop: entry below the top comes from the stack RAM
                  depth_in = depth_dec;
                  top_in   = sr_data;
                  if (depth_dec == '0) begin
                     walk_in  = root_cur;
                     phase_in = PH_WALK;
                  end else begin
                     phase_in = PH_MARK;
                  end
               end
            end
         end
      end

      // prefetch the entry just below the next top; link for the next bit
      depth_rd = depth_in - DW'(2);
      sr_addr  = depth_rd[SAW-1:0];
      tr_addr  = {walk_in[SYM_W-1:0], req_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MARK;
         depth_ff   <= '0;
         next_ff    <= NODE_FIRST;
         root_ff    <= '0;
         walk_ff    <= '0;
         shift_ff   <= '0;
         cnt_ff     <= '0;
         emitted_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         depth_ff   <= depth_in;
         next_ff    <= next_in;
         root_ff    <= root_in;
         walk_ff    <= walk_in;
         shift_ff   <= shift_in;
         cnt_ff     <= cnt_in;
         emitted_ff <= emitted_in;
      end
   end

   // top of stack is only read while the stack is non-empty
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // ------------------------------------------------------------------------
   // Storage
   // ------------------------------------------------------------------------
   pbhd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (2 ** LINK_AW)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (tw_en),
      .wr_addr (tw_addr),
      .wr_data (tw_data),
      .rd_addr (tr_addr),
      .rd_data (tr_data)
   );

   pbhd_ram #(
      .WIDTH ($bits(stack_entry_type)),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (sw_en),
      .wr_addr (sw_addr),
      .wr_data (sw_data),
      .rd_addr (sr_addr),
      .rd_data (sr_data)
   );

   // ------------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------------
   pbhd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (emit),
      .push_word  (emit_word),
      .pop_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_data),
      .fill       (q_fill)
   );

endmodule
